// ===== src/rhrr_pkg.sv =====
// Shared constants, codes and controller/datapath types for the register responder.
package rhrr_pkg;

   // Register table size and largest count served in one response
   localparam int REG_COUNT = 32;
   localparam int MAX_COUNT = 16;

   // Derived widths
   localparam int TBL_AW = $clog2(REG_COUNT);
   localparam int SEQ_W  = $clog2(9 + 2 * MAX_COUNT);
   localparam int CNT_W  = $clog2(MAX_COUNT + 1);

   // Transaction operation codes
   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_TABLE = 1'b1;

   // Protocol constants
   localparam logic [7:0] FC_READ_HOLDING = 8'h03;
   localparam logic [3:0] FRAME_LAST_POS  = 4'd11;

   // Controller to datapath commands
   typedef struct packed {
      logic             accept;     // request transaction taken this cycle
      logic             load_addr;  // load table read pointer with start address
      logic             emit;       // load next response byte into output register
      logic             emit_err;   // load the single error byte
      logic [SEQ_W-1:0] seq;        // position of the byte within the response
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_frame;   // current request is a frame byte
      logic frame_end;  // current frame byte is the last of its frame
      logic fc_ok;      // stored function code is read holding registers
      logic range_ok;   // stored start and count are within the table
      logic seq_last;   // seq is the final byte of the response
      logic out_free;   // output register can take a byte this cycle
   } sts_type;

endpackage

// ===== src/rhrr_if.sv =====
// Valid/ready channel interfaces for request and response transactions.
interface rhrr_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic        frame_start;
   logic [7:0]  req_byte;
   logic [4:0]  table_index;
   logic [15:0] table_value;

   modport source (output valid, operation, frame_start, req_byte, table_index, table_value,
                   input ready);
   modport sink   (input valid, operation, frame_start, req_byte, table_index, table_value,
                   output ready);
endinterface

interface rhrr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] resp_byte;
   logic       last;
   logic       status;

   modport source (output valid, resp_byte, last, status, input ready);
   modport sink   (input valid, resp_byte, last, status, output ready);
endinterface

// ===== src/rhrr_ctrl.sv =====
// Controller state machine: request intake, range check and response sequencing.
module rhrr_ctrl
   import rhrr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_ERR   = 2'd2;
   localparam logic [1:0] ST_SEND  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      seq_in        = seq_ff;
      req_ready     = 1'b0;
      cmd.accept    = 1'b0;
      cmd.load_addr = 1'b0;
      cmd.emit      = 1'b0;
      cmd.emit_err  = 1'b0;
      cmd.seq       = seq_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && sts.is_frame && sts.frame_end) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            seq_in        = '0;
            cmd.load_addr = 1'b1;
            if (!sts.fc_ok) begin
               state_in = ST_IDLE;
            end else if (!sts.range_ok) begin
               state_in = ST_ERR;
            end else begin
               state_in = ST_SEND;
            end
         end
         ST_ERR: begin
            if (sts.out_free) begin
               cmd.emit_err = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SEND: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               seq_in   = seq_ff + 1'b1;
               if (sts.seq_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seq_ff   <= '0;
      end else begin
         state_ff <= state_in;
         seq_ff   <= seq_in;
      end
   end

   // The check state is always left in the cycle after it is entered
   a_check_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |=> state_ff != ST_CHECK)
      else $error("check state held more than one cycle");

   // Bytes are only loaded into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.emit_err) |-> sts.out_free)
      else $error("response byte loaded over a pending one");

   // A response only starts after a passed check
   a_send_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND && $past(state_ff) != ST_SEND) |->
         ($past(state_ff) == ST_CHECK && $past(sts.fc_ok) && $past(sts.range_ok)))
      else $error("response started without a passed check");

endmodule

// ===== src/rhrr_dp.sv =====
// Datapath: frame field capture, register table, range check and response byte output.
module rhrr_dp
   import rhrr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic        operation,
   input  logic        frame_start,
   input  logic [7:0]  req_byte,
   input  logic [4:0]  table_index,
   input  logic [15:0] table_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_resp_byte,
   output logic        rsp_last,
   output logic        rsp_status
);

   // Frame byte positions
   localparam logic [3:0] POS_TID_HI   = 4'd0;
   localparam logic [3:0] POS_TID_LO   = 4'd1;
   localparam logic [3:0] POS_UNIT     = 4'd6;
   localparam logic [3:0] POS_FC       = 4'd7;
   localparam logic [3:0] POS_START_HI = 4'd8;
   localparam logic [3:0] POS_START_LO = 4'd9;
   localparam logic [3:0] POS_CNT_HI   = 4'd10;
   localparam logic [3:0] POS_CNT_LO   = 4'd11;

   // Response header byte positions
   localparam logic [SEQ_W-1:0] SEQ_TID_HI = SEQ_W'(0);
   localparam logic [SEQ_W-1:0] SEQ_TID_LO = SEQ_W'(1);
   localparam logic [SEQ_W-1:0] SEQ_PID_HI = SEQ_W'(2);
   localparam logic [SEQ_W-1:0] SEQ_PID_LO = SEQ_W'(3);
   localparam logic [SEQ_W-1:0] SEQ_LEN_HI = SEQ_W'(4);
   localparam logic [SEQ_W-1:0] SEQ_LEN_LO = SEQ_W'(5);
   localparam logic [SEQ_W-1:0] SEQ_UNIT   = SEQ_W'(6);
   localparam logic [SEQ_W-1:0] SEQ_FC     = SEQ_W'(7);
   localparam logic [SEQ_W-1:0] SEQ_BCNT   = SEQ_W'(8);

   logic [3:0]        pos_ff, pos_in, pos_cur;
   logic [15:0]       tid_ff, tid_in;
   logic [7:0]        unit_ff, unit_in;
   logic [7:0]        fc_ff, fc_in;
   logic [15:0]       start_ff, start_in;
   logic [15:0]       count_ff, count_in;
   logic              frame_take;

   logic [15:0]       tbl_mem [REG_COUNT];
   logic [REG_COUNT-1:0] tbl_vld_ff;
   logic [TBL_AW-1:0] addr_ff, addr_in;
   logic [15:0]       rd_data_ff;
   logic              rd_vld_ff;
   logic [15:0]       rd_word;
   logic              tbl_write;

   logic [7:0]        byte_cnt;
   logic [7:0]        len_lo;
   logic [7:0]        byte_mux;
   logic              data_lo;

   logic              rsp_valid_ff;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_last_ff;
   logic              rsp_status_ff;

   // Frame byte capture
   assign frame_take = cmd.accept && (operation == OP_FRAME);
   assign pos_cur    = frame_start ? POS_TID_HI : pos_ff;

   always_comb begin
      pos_in   = pos_ff;
      tid_in   = tid_ff;
      unit_in  = unit_ff;
      fc_in    = fc_ff;
      start_in = start_ff;
      count_in = count_ff;
      if (frame_take) begin
         unique case (pos_cur)
            POS_TID_HI:   tid_in   = {req_byte, tid_ff[7:0]};
            POS_TID_LO:   tid_in   = {tid_ff[15:8], req_byte};
            POS_UNIT:     unit_in  = req_byte;
            POS_FC:       fc_in    = req_byte;
            POS_START_HI: start_in = {req_byte, start_ff[7:0]};
            POS_START_LO: start_in = {start_ff[15:8], req_byte};
            POS_CNT_HI:   count_in = {req_byte, count_ff[7:0]};
            POS_CNT_LO:   count_in = {count_ff[15:8], req_byte};
            default: ;
         endcase
         pos_in = (pos_cur >= FRAME_LAST_POS) ? 4'd0 : pos_cur + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         tid_ff   <= '0;
         unit_ff  <= '0;
         fc_ff    <= '0;
         start_ff <= '0;
         count_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         tid_ff   <= tid_in;
         unit_ff  <= unit_in;
         fc_ff    <= fc_in;
         start_ff <= start_in;
         count_ff <= count_in;
      end
   end

   // Register table write with per-entry valid bits; invalid entries read as zero
   assign tbl_write = cmd.accept && (operation == OP_TABLE) && (32'(table_index) < REG_COUNT);

   always_ff @(posedge clock) begin
      if (tbl_write) begin
         tbl_mem[TBL_AW'(table_index)] <= table_value;
      end
      rd_data_ff <= tbl_mem[addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (tbl_write) begin
            tbl_vld_ff[TBL_AW'(table_index)] <= 1'b1;
         end
         rd_vld_ff <= tbl_vld_ff[addr_in];
      end
   end

   assign rd_word = rd_vld_ff ? rd_data_ff : 16'h0000;

   // Read pointer: loaded with start, advanced after each low data byte
   assign data_lo = (cmd.seq > SEQ_BCNT) && !cmd.seq[0];

   always_comb begin
      addr_in = addr_ff;
      if (cmd.load_addr) begin
         addr_in = start_ff[TBL_AW-1:0];
      end else if (cmd.emit && data_lo) begin
         addr_in = addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   // Response byte selection
   assign byte_cnt = 8'({count_ff[CNT_W-1:0], 1'b0});
   assign len_lo   = byte_cnt + 8'd3;

   always_comb begin
      unique case (cmd.seq)
         SEQ_TID_HI: byte_mux = tid_ff[15:8];
         SEQ_TID_LO: byte_mux = tid_ff[7:0];
         SEQ_PID_HI: byte_mux = 8'h00;
         SEQ_PID_LO: byte_mux = 8'h00;
         SEQ_LEN_HI: byte_mux = 8'h00;
         SEQ_LEN_LO: byte_mux = len_lo;
         SEQ_UNIT:   byte_mux = unit_ff;
         SEQ_FC:     byte_mux = FC_READ_HOLDING;
         SEQ_BCNT:   byte_mux = byte_cnt;
         default:    byte_mux = cmd.seq[0] ? rd_word[15:8] : rd_word[7:0];
      endcase
   end

   // Status to controller
   assign sts.is_frame  = (operation == OP_FRAME);
   assign sts.frame_end = (pos_cur >= FRAME_LAST_POS);
   assign sts.fc_ok     = (fc_ff == FC_READ_HOLDING);
   assign sts.range_ok  = (count_ff != 16'd0) && (32'(count_ff) <= MAX_COUNT) &&
                          ((17'(start_ff) + 17'(count_ff)) <= 17'(REG_COUNT));
   assign sts.seq_last  = (cmd.seq == SEQ_W'(SEQ_BCNT + SEQ_W'({count_ff[CNT_W-1:0], 1'b0})));
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.emit_err) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_err) begin
         rsp_byte_ff   <= 8'h00;
         rsp_last_ff   <= 1'b1;
         rsp_status_ff <= 1'b1;
      end else if (cmd.emit) begin
         rsp_byte_ff   <= byte_mux;
         rsp_last_ff   <= sts.seq_last;
         rsp_status_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_resp_byte = rsp_byte_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_status    = rsp_status_ff;

   // An error byte is always the last of its run
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_err |=> (rsp_valid_ff && rsp_last_ff && rsp_byte_ff == 8'h00))
      else $error("error byte not marked last");

   // Frame position never leaves the twelve-byte frame
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= FRAME_LAST_POS)
      else $error("frame position out of range");

endmodule

// ===== src/read_holding_register_responder.sv =====
// Top level: read holding registers responder with a 32-word register table.
// Request transactions carry either one byte of a 12-byte request frame or one
// table word write; while the request side is ready, a frame streams in at one
// byte per cycle. After the twelfth byte it checks the function code and
// range in its check state, then sends the response at one byte per cycle from
// its output register while the receiver takes each byte: 9+2N bytes for a
// valid read of N registers, a single error byte (status 1) for a bad range,
// nothing for other function codes. The request side is held off from the
// last frame byte until the final response byte is loaded, or until the check
// ends when nothing is sent. Table words read through one registered memory
// port, one word every two response bytes; the table reads as zero after reset
// until written.
module read_holding_register_responder
   import rhrr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   rhrr_req_if.sink   req_chan,
   rhrr_rsp_if.source rsp_chan
);

   cmd_type cmd;
   sts_type sts;

   rhrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rhrr_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .operation     (req_chan.operation),
      .frame_start   (req_chan.frame_start),
      .req_byte      (req_chan.req_byte),
      .table_index   (req_chan.table_index),
      .table_value   (req_chan.table_value),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_resp_byte (rsp_chan.resp_byte),
      .rsp_last      (rsp_chan.last),
      .rsp_status    (rsp_chan.status)
   );

endmodule

// ===== tb/tb.sv =====
// Testbench for the read holding registers responder: directed and random frames, checked bytewise.
`timescale 1ns / 1ps

module tb
   import rhrr_pkg::*;
();

   localparam int ITEM_TARGET  = 460;
   localparam int TAIL_ITEMS   = 60;     // last requests go out with no idling
   localparam int HOLD_AFTER   = 60;     // response bytes taken before the long hold
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 64;     // margin for the check state plus the longest response
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct {
      logic        operation;
      logic        frame_start;
      logic [7:0]  req_byte;
      logic [4:0]  table_index;
      logic [15:0] table_value;
   } request_type;

   typedef struct {
      logic [7:0] resp_byte;
      logic       last;
      logic       status;
   } resp_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rhrr_req_if req_chan ();
   rhrr_rsp_if rsp_chan ();

   read_holding_register_responder u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #4 clock = ~clock;

   request_type   pending_requests[$];
   resp_beat_type expected_bytes[$];
   logic          calm_tail = 1'b0;
   int            error_count = 0;
   int            cycle_count = 0;

   // Shadow copy of the responder state
   logic [3:0]  frame_pos   = '0;
   logic [15:0] txn_id      = '0;
   logic [7:0]  unit_addr   = '0;
   logic [7:0]  func_code   = '0;
   logic [15:0] start_addr  = '0;
   logic [15:0] word_count  = '0;
   logic [15:0] table_words[REG_COUNT];

   initial begin
      foreach (table_words[i]) table_words[i] = '0;
   end

   function automatic void push_expected(input logic [7:0] b, input logic last,
                                         input logic status);
      resp_beat_type beat;
      beat.resp_byte = b;
      beat.last      = last;
      beat.status    = status;
      expected_bytes.push_back(beat);
   endfunction

   // Advance the shadow state by one request; queue the response bytes it causes
   function automatic void predict_response_bytes(input request_type rq);
      logic [15:0] frame_len;
      logic [15:0] word;
      int          n;
      if (rq.operation == OP_TABLE) begin
         // 5-bit index always lands inside the 32-word table
         table_words[rq.table_index] = rq.table_value;
      end else begin
         if (rq.frame_start) frame_pos = '0;
         case (frame_pos)
            4'd0: txn_id[15:8]     = rq.req_byte;
            4'd1: txn_id[7:0]      = rq.req_byte;
            4'd6: unit_addr        = rq.req_byte;
            4'd7: func_code        = rq.req_byte;
            4'd8: start_addr[15:8] = rq.req_byte;
            4'd9: start_addr[7:0]  = rq.req_byte;
            4'd10: word_count[15:8] = rq.req_byte;
            4'd11: word_count[7:0]  = rq.req_byte;
            default: ;
         endcase
         if (frame_pos >= FRAME_LAST_POS) begin
            frame_pos = '0;
            n = int'(word_count);
            if (func_code != FC_READ_HOLDING) begin
               // other function codes: silent
            end else if (n == 0 || n > MAX_COUNT || int'(start_addr) + n > REG_COUNT) begin
               push_expected(8'h00, 1'b1, 1'b1);
            end else begin
               frame_len = 16'(3 + 2 * n);
               push_expected(txn_id[15:8], 1'b0, 1'b0);
               push_expected(txn_id[7:0], 1'b0, 1'b0);
               push_expected(8'h00, 1'b0, 1'b0);
               push_expected(8'h00, 1'b0, 1'b0);
               push_expected(frame_len[15:8], 1'b0, 1'b0);
               push_expected(frame_len[7:0], 1'b0, 1'b0);
               push_expected(unit_addr, 1'b0, 1'b0);
               push_expected(FC_READ_HOLDING, 1'b0, 1'b0);
               push_expected(8'(2 * n), 1'b0, 1'b0);
               for (int a = 0; a < n; a++) begin
                  word = table_words[int'(start_addr) + a];
                  push_expected(word[15:8], 1'b0, 1'b0);
                  push_expected(word[7:0], a == n - 1, 1'b0);
               end
            end
         end else begin
            frame_pos = frame_pos + 4'd1;
         end
      end
   endfunction

   // Stimulus builders
   task automatic add_table_write(input logic [4:0] idx, input logic [15:0] val);
      request_type rq;
      rq.operation   = OP_TABLE;
      rq.frame_start = 1'($urandom);
      rq.req_byte    = 8'($urandom);
      rq.table_index = idx;
      rq.table_value = val;
      pending_requests.push_back(rq);
   endtask

   task automatic add_frame_byte(input logic mark, input logic [7:0] b);
      request_type rq;
      rq.operation   = OP_FRAME;
      rq.frame_start = mark;
      rq.req_byte    = b;
      rq.table_index = 5'($urandom);
      rq.table_value = 16'($urandom);
      pending_requests.push_back(rq);
   endtask

   // Full 12-byte request; a table write slips in before byte stray_pos (-1: none)
   task automatic add_read_frame(input logic mark, input logic [15:0] tid,
                                 input logic [7:0] unit, input logic [7:0] fc,
                                 input logic [15:0] start, input logic [15:0] count,
                                 input int stray_pos);
      logic [7:0] frame[12];
      frame = '{tid[15:8], tid[7:0], 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), unit, fc, start[15:8], start[7:0], count[15:8], count[7:0]};
      for (int i = 0; i < 12; i++) begin
         if (i == stray_pos) add_table_write(5'($urandom), 16'($urandom));
         add_frame_byte(i == 0 ? mark : 1'b0, frame[i]);
      end
   endtask

   task automatic add_partial_frame(input int len);
      for (int i = 0; i < len; i++) add_frame_byte(i == 0, 8'($urandom));
   endtask

   // Request driver
   always @(posedge clock) begin : drive_requests
      int          gap_left;
      request_type cur;
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_response_bytes(pending_requests.pop_front());
         calm_tail <= (pending_requests.size() <= TAIL_ITEMS);
         if (req_chan.valid && !req_chan.ready) begin
            // offer stays up until taken
         end else if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (pending_requests.size() == 0) begin
            req_chan.valid <= 1'b0;
         end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(0, 5);
            req_chan.valid <= 1'b0;
         end else begin
            cur = pending_requests[0];
            req_chan.valid       <= 1'b1;
            req_chan.operation   <= cur.operation;
            req_chan.frame_start <= cur.frame_start;
            req_chan.req_byte    <= cur.req_byte;
            req_chan.table_index <= cur.table_index;
            req_chan.table_value <= cur.table_value;
         end
      end
   end

   // Response ready: random stall bursts plus one long hold
   always @(posedge clock) begin : drive_rsp_ready
      int stall_left;
      int hold_left;
      int bytes_taken;
      bit hold_used;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left  = 0;
         hold_left   = 0;
         bytes_taken = 0;
         hold_used   = 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) bytes_taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!hold_used && bytes_taken >= HOLD_AFTER) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Response checker
   always @(posedge clock) begin : check_responses
      resp_beat_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_bytes.size() == 0) begin
            if (error_count < 10)
               $display("unexpected response: byte %02h last %0b status %0b",
                        rsp_chan.resp_byte, rsp_chan.last, rsp_chan.status);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_chan.resp_byte !== want.resp_byte || rsp_chan.last !== want.last ||
                rsp_chan.status !== want.status) begin
               if (error_count < 10)
                  $display("mismatch: expected byte %02h last %0b status %0b, got %02h %0b %0b",
                           want.resp_byte, want.last, want.status,
                           rsp_chan.resp_byte, rsp_chan.last, rsp_chan.status);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [7:0]  fc;
      logic [15:0] count;
      logic [15:0] start;
      logic        mark;
      bit          chained_ok;
      int          pick;
      int          kind;
      int          stray;

      req_chan.valid       = 1'b0;
      req_chan.operation   = OP_FRAME;
      req_chan.frame_start = 1'b0;
      req_chan.req_byte    = '0;
      req_chan.table_index = '0;
      req_chan.table_value = '0;
      rsp_chan.ready       = 1'b0;

      // Directed: table extremes, aborted frame, write inside a frame, chained error frame
      add_table_write(5'd0, 16'hFFFF);
      add_table_write(5'd31, 16'h8001);
      add_partial_frame(3);
      add_read_frame(1'b1, 16'hFFFF, 8'hFF, FC_READ_HOLDING, 16'd31, 16'd1, 5);
      add_read_frame(1'b0, 16'h0000, 8'h00, FC_READ_HOLDING, 16'd0, 16'd0, -1);

      // Random: mostly well-formed reads, some bad ranges, noise and aborted frames
      chained_ok = 1'b1;
      while (pending_requests.size() < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            add_table_write(5'($urandom), 16'($urandom));
         end else if (pick < 14) begin
            add_partial_frame($urandom_range(1, 11));
            chained_ok = 1'b0;
         end else begin
            fc = ($urandom_range(0, 9) < 8) ? FC_READ_HOLDING : 8'($urandom);
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
               count = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(9, MAX_COUNT))
                                                   : 16'($urandom_range(1, 4));
               start = 16'($urandom_range(0, REG_COUNT - int'(count)));
            end else if (kind == 7) begin
               // zero count or above the limit
               count = $urandom_range(0, 1) ? 16'd0
                                            : 16'($urandom_range(MAX_COUNT + 1, 16'hFFFF));
               start = 16'($urandom_range(0, REG_COUNT - 1));
            end else if (kind == 8) begin
               // range runs past the table end
               count = 16'($urandom_range(1, MAX_COUNT));
               start = 16'($urandom_range(REG_COUNT - int'(count) + 1, REG_COUNT + 8));
            end else begin
               count = 16'($urandom);
               start = 16'($urandom);
            end
            mark  = chained_ok ? 1'($urandom) : 1'b1;
            stray = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 11) : -1;
            add_read_frame(mark, 16'($urandom), 8'($urandom), fc, start, count, stray);
            chained_ok = 1'b1;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_chan.valid || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
